[hw/rtl/csbp_pkg.sv]
// package for the code and symbol bit packer
// holds field widths, op codes and the control record passed between the
// packer core and the byte serializer; depends on nothing
package csbp_pkg;

  // field widths
  localparam int unsigned CodeWidth    = 16;
  localparam int unsigned CodeLenWidth = 5;
  localparam int unsigned SymbolWidth  = 8;
  localparam int unsigned ByteWidth    = 8;
  localparam int unsigned PendWidth    = ByteWidth - 1;
  localparam int unsigned PendCntWidth = 3;
  localparam int unsigned MaxBytes     = 3;
  localparam int unsigned ByteCntWidth = 2;
  localparam int unsigned AccWidth     = PendWidth + CodeWidth + SymbolWidth;
  localparam int unsigned TotalWidth   = 5;

  // longest code length honored; longer requests are saturated
  localparam int unsigned MaxCodeBits  = 16;
  localparam int unsigned EffCodeBits  = (MaxCodeBits < CodeWidth) ? MaxCodeBits : CodeWidth;

  // request op codes
  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_FLUSH  = 1'b1
  } csbp_op_e;

  // load record from packer core to serializer
  typedef struct packed {
    logic                                valid;
    logic [ByteCntWidth-1:0]             nbytes;
    logic [MaxBytes*ByteWidth-1:0]       data;
  } csbp_load_t;

endpackage

[hw/rtl/csbp_if.sv]
// handshake channels of the code and symbol bit packer
// input request channel and output byte channel; depends on csbp_pkg
interface csbp_item_if;
  import csbp_pkg::*;

  logic                    valid;
  logic                    ready;
  csbp_op_e                op;
  logic [CodeWidth-1:0]    code_value;
  logic [CodeLenWidth-1:0] code_bits;
  logic [SymbolWidth-1:0]  symbol;

  modport source (output valid, output op, output code_value, output code_bits,
                  output symbol, input ready);
  modport sink   (input valid, input op, input code_value, input code_bits,
                  input symbol, output ready);
endinterface

interface csbp_byte_if;
  import csbp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ByteWidth-1:0] out_byte;
  logic                 last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

[hw/rtl/csbp_packer.sv]
// packer core: merges pending bits, code and symbol into a packed word
// and keeps the partial-byte accumulator; depends on csbp_pkg
module csbp_packer (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   accept_i,
  input  csbp_pkg::csbp_op_e                     op_i,
  input  logic [csbp_pkg::CodeWidth-1:0]         code_value_i,
  input  logic [csbp_pkg::CodeLenWidth-1:0]      code_bits_i,
  input  logic [csbp_pkg::SymbolWidth-1:0]       symbol_i,
  output csbp_pkg::csbp_load_t                   load_o
);
  import csbp_pkg::*;

  logic [PendWidth-1:0]    pend_q, pend_d;
  logic [PendCntWidth-1:0] cnt_q, cnt_d;

  logic [CodeLenWidth-1:0] len;
  logic [CodeWidth-1:0]    code_masked;
  logic [AccWidth-1:0]     acc;
  logic [TotalWidth-1:0]   total;
  logic [ByteCntWidth-1:0] app_nbytes;
  logic [AccWidth-1:0]     acc_rest;
  logic [PendWidth-1:0]    rest_mask;

  // saturate the code length and drop unused code bits
  always_comb begin
    len = (code_bits_i > CodeLenWidth'(EffCodeBits)) ? CodeLenWidth'(EffCodeBits)
                                                      : code_bits_i;
    code_masked = code_value_i & CodeWidth'((17'(1) << len) - 17'd1);
  end

  // build the bit word; pending bits above cnt_q are always zero
  always_comb begin
    acc = AccWidth'(pend_q)
        | (AccWidth'(code_masked) << cnt_q)
        | (AccWidth'(symbol_i) << (TotalWidth'(cnt_q) + len));
    total      = TotalWidth'(cnt_q) + len + TotalWidth'(ByteWidth);
    app_nbytes = total[TotalWidth-1:3];
    acc_rest   = acc >> {app_nbytes, 3'b000};
    rest_mask  = PendWidth'((8'(1) << total[2:0]) - 8'd1);
  end

  // load record and next accumulator state
  always_comb begin
    pend_d = pend_q;
    cnt_d  = cnt_q;
    load_o = '0;
    if (accept_i) begin
      load_o.valid = 1'b1;
      if (op_i == OP_FLUSH) begin
        load_o.nbytes = (cnt_q != '0) ? ByteCntWidth'(1) : '0;
        load_o.data   = (MaxBytes*ByteWidth)'(pend_q);
        pend_d        = '0;
        cnt_d         = '0;
      end else begin
        load_o.nbytes = app_nbytes;
        load_o.data   = acc[MaxBytes*ByteWidth-1:0];
        pend_d        = acc_rest[PendWidth-1:0] & rest_mask;
        cnt_d         = total[2:0];
      end
    end
  end

  // accumulator registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cnt_q  <= '0;
    end else begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

  // pending bits never extend past the pending count
  a_pend_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q >> cnt_q) == '0)
    else $error("pending bits above pending count");

  // a flush leaves the accumulator empty
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && op_i == OP_FLUSH) |=> (cnt_q == '0 && pend_q == '0))
    else $error("accumulator not cleared by flush");

  // an append always yields at least one byte
  a_append_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && op_i == OP_APPEND) |-> (load_o.nbytes != '0))
    else $error("append produced no byte");

endmodule

[hw/rtl/csbp_serializer.sv]
// byte serializer: result register holding up to three packed bytes,
// sent one per cycle while the output is ready, last flag on the final one; depends on csbp_pkg
module csbp_serializer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  csbp_pkg::csbp_load_t                load_i,
  input  logic                                out_ready_i,
  output logic                                can_load_o,
  output logic                                out_valid_o,
  output logic [csbp_pkg::ByteWidth-1:0]      out_byte_o,
  output logic                                out_last_o
);
  import csbp_pkg::*;

  logic [MaxBytes*ByteWidth-1:0] buf_q, buf_d;
  logic [ByteCntWidth-1:0]       left_q, left_d;
  logic                          out_fire;

  // output view of the head byte
  assign out_valid_o = (left_q != '0);
  assign out_byte_o  = buf_q[ByteWidth-1:0];
  assign out_last_o  = (left_q == ByteCntWidth'(1));
  assign out_fire    = out_valid_o && out_ready_i;

  // a new request may load when the buffer is empty or empties this cycle
  assign can_load_o = (left_q == '0) || (out_last_o && out_ready_i);

  // buffer update: load a fresh word or shift out one byte
  always_comb begin
    buf_d  = buf_q;
    left_d = left_q;
    if (load_i.valid) begin
      buf_d  = load_i.data;
      left_d = load_i.nbytes;
    end else if (out_fire) begin
      buf_d  = buf_q >> ByteWidth;
      left_d = left_q - ByteCntWidth'(1);
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else begin
      left_q <= left_d;
    end
  end

  // a load never overwrites bytes still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i.valid |-> (left_q == '0 || (left_q == ByteCntWidth'(1) && out_ready_i)))
    else $error("load over pending bytes");

  // after a non-final byte is taken another byte follows
  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !out_last_o) |=> out_valid_o)
    else $error("byte sequence cut short");

  // buffer never holds more than three bytes
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= ByteCntWidth'(MaxBytes))
    else $error("byte count out of range");

endmodule

[hw/rtl/code_symbol_bit_packer.sv]
// Packs code and symbol requests into an LSB-first byte stream. Each append
// request adds its code bits (length saturated to 16) and then its 8 symbol
// bits to a partial-byte accumulator; each finished byte comes out on the
// byte channel, first bit in bit 0, and the final byte of a request carries
// last. A flush request sends the remaining partial byte zero-padded, or
// nothing if none is pending, and empties the accumulator. An append
// produces 1 to 3 bytes and a flush 0 or 1; the output byte register sends
// one byte a cycle while the output is ready, and a request is taken in the
// same cycle the previous request's final byte goes out, or at once while
// the register is empty. Packing is done in the cycle a request is accepted.
// Depends on csbp_pkg, csbp_if, csbp_packer and csbp_serializer.
module code_symbol_bit_packer (
  input  logic       clk_i,
  input  logic       rst_ni,
  csbp_item_if.sink  item_i,
  csbp_byte_if.source byte_o
);
  import csbp_pkg::*;

  csbp_load_t load;
  logic       can_load;
  logic       accept;

  assign item_i.ready = can_load;
  assign accept       = item_i.valid && can_load;

  // packer core and accumulator
  csbp_packer u_packer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .op_i         (item_i.op),
    .code_value_i (item_i.code_value),
    .code_bits_i  (item_i.code_bits),
    .symbol_i     (item_i.symbol),
    .load_o       (load)
  );

  // result register and byte sequencing
  csbp_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .out_ready_i (byte_o.ready),
    .can_load_o  (can_load),
    .out_valid_o (byte_o.valid),
    .out_byte_o  (byte_o.out_byte),
    .out_last_o  (byte_o.last)
  );

endmodule

[verif/tb_code_symbol_bit_packer.sv]
// self-checking testbench for code_symbol_bit_packer
// predicts the packed byte stream of each request; uses csbp_pkg, csbp_if and the block
module tb_code_symbol_bit_packer;
  import csbp_pkg::*;

  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned RandomItems = 38;

  typedef struct packed {
    logic [ByteWidth-1:0] data;
    logic                 last;
  } packed_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  csbp_item_if item_ch ();
  csbp_byte_if byte_ch ();

  code_symbol_bit_packer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_ch),
    .byte_o (byte_ch)
  );

  // bytes still owed by the block, oldest first
  packed_byte_t            pending_bytes[$];
  // bit accumulator of the model
  logic [PendWidth-1:0]    acc_bits  = '0;
  logic [PendCntWidth-1:0] acc_count = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          errors        = 0;
  int          stall_cycles  = 0;
  int          hold_left     = 0;
  logic        hold_req      = 1'b0;
  logic        hold_ack      = 1'b0;

  always #5 clk_i = ~clk_i;

  // model of the packer: append code and symbol bits, emit full bytes
  function automatic void pack_request(csbp_op_e op, logic [CodeWidth-1:0] code,
                                       logic [CodeLenWidth-1:0] len_raw,
                                       logic [SymbolWidth-1:0] sym);
    logic [AccWidth-1:0]  acc;
    logic [CodeWidth-1:0] cmask;
    int unsigned          len;
    int unsigned          total;
    packed_byte_t         b;
    if (op == OP_FLUSH) begin
      // partial byte goes out zero-padded, empty accumulator sends nothing
      if (acc_count != 0) begin
        b.data = ByteWidth'(acc_bits);
        b.last = 1'b1;
        pending_bytes.push_back(b);
      end
      acc_bits  = '0;
      acc_count = '0;
      return;
    end
    len   = (len_raw > EffCodeBits) ? EffCodeBits : len_raw;
    cmask = CodeWidth'((32'h1 << len) - 1);
    acc   = AccWidth'(acc_bits)
          | (AccWidth'(code & cmask) << acc_count)
          | (AccWidth'(sym) << (acc_count + len));
    total = acc_count + len + ByteWidth;
    while (total >= ByteWidth) begin
      b.data = acc[ByteWidth-1:0];
      b.last = (total < 2 * ByteWidth);
      pending_bytes.push_back(b);
      acc   = acc >> ByteWidth;
      total = total - ByteWidth;
    end
    acc_count = PendCntWidth'(total);
    acc_bits  = PendWidth'(acc);
  endfunction

  // predict on every accepted request
  always @(posedge clk_i) begin
    if (rst_ni && item_ch.valid && item_ch.ready) begin
      pack_request(item_ch.op, item_ch.code_value, item_ch.code_bits, item_ch.symbol);
    end
  end

  // compare every accepted byte with the oldest prediction
  always @(posedge clk_i) begin
    packed_byte_t want;
    if (rst_ni && byte_ch.valid && byte_ch.ready) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual out_byte %h last %b",
                 $time, byte_ch.out_byte, byte_ch.last);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (byte_ch.out_byte !== want.data) begin
          $display("%0t: out_byte mismatch: expected %h, actual %h",
                   $time, want.data, byte_ch.out_byte);
          errors++;
        end
        if (byte_ch.last !== want.last) begin
          $display("%0t: last mismatch: expected %b, actual %b",
                   $time, want.last, byte_ch.last);
          errors++;
        end
      end
    end
  end

  // output side: long hold-off on request, random stalls otherwise
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      byte_ch.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack      <= hold_req;
      hold_left     <= HoldCycles;
      byte_ch.ready <= 1'b0;
    end else begin
      byte_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((item_ch.valid && item_ch.ready) || (byte_ch.valid && byte_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // offer one request and wait until it is taken
  task automatic send_request(input csbp_op_e op, input logic [CodeWidth-1:0] code,
                              input logic [CodeLenWidth-1:0] len,
                              input logic [SymbolWidth-1:0] sym);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_ch.valid      <= 1'b1;
    item_ch.op         <= op;
    item_ch.code_value <= code;
    item_ch.code_bits  <= len;
    item_ch.symbol     <= sym;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
  endtask

  // mostly appends with legal lengths, some flushes and saturated lengths
  task automatic send_random_request();
    csbp_op_e                op;
    logic [CodeLenWidth-1:0] len;
    op  = ($urandom_range(99) < 20) ? OP_FLUSH : OP_APPEND;
    len = ($urandom_range(99) < 85) ? CodeLenWidth'($urandom_range(16))
                                    : CodeLenWidth'($urandom_range(31, 17));
    send_request(op, CodeWidth'($urandom), len, SymbolWidth'($urandom));
  endtask

  // stop offering and wait for every predicted byte
  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_bytes.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // field extremes, zero and saturated lengths, padding, empty flushes
  task automatic test_directed();
    send_request(OP_APPEND, 16'h0000, 5'd0,  8'h00);
    send_request(OP_APPEND, 16'hffff, 5'd0,  8'hff);
    send_request(OP_APPEND, 16'hffff, 5'd16, 8'ha5);
    send_request(OP_APPEND, 16'h0001, 5'd1,  8'h00);
    send_request(OP_FLUSH,  16'h0000, 5'd0,  8'h00);
    send_request(OP_FLUSH,  16'hffff, 5'd31, 8'hff);
    send_request(OP_APPEND, 16'h007f, 5'd7,  8'h80);
    send_request(OP_APPEND, 16'h0000, 5'd0,  8'hff);
    send_request(OP_FLUSH,  16'h1234, 5'd5,  8'h5a);
    send_request(OP_APPEND, 16'hffff, 5'd17, 8'h00);
    send_request(OP_APPEND, 16'hffff, 5'd31, 8'h3c);
    send_request(OP_APPEND, 16'h5555, 5'd15, 8'h81);
    send_request(OP_APPEND, 16'h00aa, 5'd3,  8'h7e);
    send_request(OP_FLUSH,  16'h0000, 5'd0,  8'h00);
    send_request(OP_FLUSH,  16'h0000, 5'd0,  8'h00);
    send_request(OP_APPEND, 16'hfffe, 5'd1,  8'h00);
    send_request(OP_APPEND, 16'h8000, 5'd16, 8'hff);
    send_request(OP_APPEND, 16'hffff, 5'd8,  8'h00);
    send_request(OP_FLUSH,  16'hffff, 5'd16, 8'hff);
    send_request(OP_APPEND, 16'hffff, 5'd16, 8'hff);
    send_request(OP_APPEND, 16'h01ff, 5'd9,  8'h7f);
    send_request(OP_FLUSH,  16'h0000, 5'd0,  8'h00);
  endtask

  task automatic test_random(input int unsigned count);
    repeat (count) send_random_request();
  endtask

  // output held off long enough for the block to stall its input
  task automatic test_output_hold();
    hold_req <= ~hold_req;
    repeat (24) send_random_request();
  endtask

  // sender waits for the block to empty, then starts again
  task automatic test_pause_after_drain();
    repeat (10) send_random_request();
    wait_drained();
    repeat (8) @(posedge clk_i);
    repeat (10) send_random_request();
  endtask

  initial begin
    item_ch.valid      = 1'b0;
    item_ch.op         = OP_APPEND;
    item_ch.code_value = '0;
    item_ch.code_bits  = '0;
    item_ch.symbol     = '0;
    byte_ch.ready      = 1'b0;
    rst_ni             = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_idling(11, 80);
    test_directed();
    test_random(RandomItems);
    set_idling(80, 11);
    test_random(RandomItems);
    set_idling(0, 0);
    test_random(RandomItems);
    test_output_hold();
    test_pause_after_drain();

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
